// ===== hdl/eff_pkg.sv =====
// Shared types, constants and helpers of the egress flow filter and rate limiter.
package eff_pkg;

  localparam int unsigned BLK_DEPTH   = 1024;
  localparam int unsigned RATE_DEPTH  = 8192;
  localparam int unsigned BLK_AW      = (BLK_DEPTH > 1) ? $clog2(BLK_DEPTH) : 1;
  localparam int unsigned RATE_AW     = (RATE_DEPTH > 1) ? $clog2(RATE_DEPTH) : 1;
  localparam int unsigned BLK_CW      = $clog2(BLK_DEPTH + 1);
  localparam int unsigned RATE_CW     = $clog2(RATE_DEPTH + 1);
  localparam int unsigned SCAN_W      = (BLK_CW > RATE_CW) ? BLK_CW : RATE_CW;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned Q_AW        = $clog2(QUEUE_DEPTH);
  localparam int unsigned Q_CW        = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned CFG_AW      = 1;
  localparam int unsigned CFG_DW      = 32;
  localparam logic [CFG_AW-1:0] CFG_WINDOW_LEN = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] CFG_BYTE_LIMIT = CFG_AW'(1);
  localparam logic [CFG_DW-1:0] WINDOW_LEN_RST = 32'd1000000000;
  localparam logic [CFG_DW-1:0] BYTE_LIMIT_RST = 32'd104857600;

  localparam logic [7:0] PROTO_TCP        = 8'd6;
  localparam logic [7:0] PROTO_UDP        = 8'd17;
  localparam logic [7:0] BLOCK_QUARANTINE = 8'd1;

  localparam int unsigned N_STATS = 4;
  localparam logic [1:0] STAT_PKT_PASS  = 2'd0;
  localparam logic [1:0] STAT_PKT_DROP  = 2'd1;
  localparam logic [1:0] STAT_BYTE_PASS = 2'd2;
  localparam logic [1:0] STAT_BYTE_DROP = 2'd3;

  localparam int unsigned N_ALERT_PORTS = 8;
  localparam logic [15:0] ALERT_PORTS [N_ALERT_PORTS] = '{
    16'd4444, 16'd1337, 16'd31337, 16'd6666, 16'd6667, 16'd6668, 16'd9999, 16'd12345
  };

  typedef enum logic [2:0] {
    CMD_PACKET    = 3'd0,
    CMD_WR_BLOCK  = 3'd1,
    CMD_DEL_BLOCK = 3'd2,
    CMD_ADD_RATE  = 3'd3,
    CMD_DEL_RATE  = 3'd4,
    CMD_RD_STAT   = 3'd5,
    CMD_RD_TOTAL  = 3'd6,
    CMD_NOP       = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic {
    REASON_QUARANTINE = 1'b0,
    REASON_ALERT      = 1'b1
  } reason_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [63:0] key;
    logic [7:0]  bval;
    logic [1:0]  sidx;
    logic [15:0] len;
    logic [63:0] now;
    logic        iph;
    logic        alert;
    logic [7:0]  proto;
    logic [31:0] addr;
    logic [15:0] evport;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic        drop;
    logic        event_valid;
    reason_e     event_reason;
    logic [63:0] event_flow_key;
    logic [31:0] event_address;
    logic [15:0] event_port;
    logic [7:0]  event_protocol;
    logic [15:0] event_length;
    logic [63:0] event_time;
    logic [63:0] read_data;
  } res_t;

  typedef struct packed {
    logic        used;
    logic [63:0] key;
    logic [7:0]  val;
  } blk_ent_t;

  typedef struct packed {
    logic        used;
    logic [63:0] key;
    logic [63:0] start;
    logic [63:0] wbytes;
    logic [63:0] total;
  } rate_ent_t;

  function automatic logic is_alert_port(logic [15:0] port);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < N_ALERT_PORTS; i++) begin
      if (port == ALERT_PORTS[i]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// ===== hdl/eff_ram.sv =====
// Generic simple dual-port RAM with a registered read.
module eff_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/eff_front.sv =====
// Input side: accepts items and classifies packets for the engine.
module eff_front (
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [2:0]     command_i,
  input  logic [63:0]    flow_key_i,
  input  logic [7:0]     block_value_i,
  input  logic [1:0]     stat_index_i,
  input  logic [15:0]    packet_length_i,
  input  logic [63:0]    time_now_ns_i,
  input  logic           ip_header_present_i,
  input  logic           l4_header_present_i,
  input  logic [7:0]     ip_protocol_i,
  input  logic [31:0]    dest_address_i,
  input  logic [15:0]    dest_port_i,
  input  logic           q_full_i,
  output logic           push_o,
  output eff_pkg::item_t item_o
);
  import eff_pkg::*;

  logic tcp_or_udp;

  assign tcp_or_udp = (ip_protocol_i == PROTO_TCP) || (ip_protocol_i == PROTO_UDP);
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o.cmd    = cmd_e'(command_i);
    item_o.key    = flow_key_i;
    item_o.bval   = block_value_i;
    item_o.sidx   = stat_index_i;
    item_o.len    = packet_length_i;
    item_o.now    = time_now_ns_i;
    item_o.iph    = ip_header_present_i;
    item_o.alert  = ip_header_present_i && (ip_protocol_i == PROTO_TCP) &&
                    l4_header_present_i && is_alert_port(dest_port_i);
    item_o.proto  = ip_protocol_i;
    item_o.addr   = dest_address_i;
    item_o.evport = (tcp_or_udp && l4_header_present_i) ? dest_port_i : 16'd0;
  end

endmodule

// ===== hdl/eff_queue.sv =====
// Short item queue between the classifier and the engine.
module eff_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  eff_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output eff_pkg::item_t head_o
);
  import eff_pkg::*;

  item_t            mem_q [QUEUE_DEPTH];
  logic [Q_AW-1:0]  wp_q;
  logic [Q_AW-1:0]  rp_q;
  logic [Q_CW-1:0]  cnt_q;
  logic             do_pop;

  assign full_o  = (cnt_q == Q_CW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rp_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + Q_AW'(1);
      end
      if (do_pop) begin
        rp_q <= rp_q + Q_AW'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + Q_CW'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - Q_CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue written while full");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CW'(QUEUE_DEPTH)) else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wp_q == rp_q)) else $error("queue pointers disagree with count");

endmodule

// ===== hdl/eff_back.sv =====
// Engine: table scans, rate window update, counters and the result register.
module eff_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [eff_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [eff_pkg::CFG_DW-1:0] cfg_wdata_i,
  input  logic                       q_valid_i,
  input  eff_pkg::item_t             q_item_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output eff_pkg::res_t              res_o
);
  import eff_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_CALC, ST_RATE, ST_APPLY, ST_FINISH
  } state_e;

  typedef enum logic {
    TBL_BLOCK, TBL_RATE
  } tbl_e;

  state_e              state_q;
  tbl_e                tbl_q;
  item_t               cur_q;
  res_t                res_q;
  res_t                out_q;
  logic                out_valid_q;
  logic [CFG_DW-1:0]   wlen_q;
  logic [CFG_DW-1:0]   limit_q;
  logic [63:0]         stat_q [N_STATS];
  logic [BLK_CW-1:0]   blk_hwm_q;
  logic [RATE_CW-1:0]  rate_hwm_q;

  logic [SCAN_W-1:0]   iss_q;
  logic                chk_vld_q;
  logic [SCAN_W-1:0]   chk_idx_q;
  logic                hit_q;
  logic [SCAN_W-1:0]   ent_idx_q;
  logic                free_vld_q;
  logic [SCAN_W-1:0]   free_idx_q;
  blk_ent_t            blk_ent_q;
  rate_ent_t           rate_ent_q;

  logic                win_restart_q;
  logic [63:0]         win_sum_q;
  logic [63:0]         tot_sum_q;

  logic                blk_we_q;
  logic [BLK_AW-1:0]   blk_waddr_q;
  blk_ent_t            blk_wdata_q;
  logic                rate_we_q;
  logic [RATE_AW-1:0]  rate_waddr_q;
  rate_ent_t           rate_wdata_q;

  blk_ent_t            blk_rd;
  rate_ent_t           rate_rd;
  logic                row_used;
  logic [63:0]         row_key;
  logic [SCAN_W-1:0]   scan_lim;
  logic [SCAN_W-1:0]   tbl_depth;
  logic                scan_done;
  logic [SCAN_W-1:0]   place_idx;
  logic                place_ok;
  logic                place_grow;
  logic [63:0]         elapsed;
  logic                out_free;

  eff_ram #(.WIDTH($bits(blk_ent_t)), .DEPTH(BLK_DEPTH)) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_we_q),
    .waddr_i (blk_waddr_q),
    .wdata_i (blk_wdata_q),
    .raddr_i (iss_q[BLK_AW-1:0]),
    .rdata_o (blk_rd)
  );

  eff_ram #(.WIDTH($bits(rate_ent_t)), .DEPTH(RATE_DEPTH)) u_rate_ram (
    .clk_i   (clk_i),
    .we_i    (rate_we_q),
    .waddr_i (rate_waddr_q),
    .wdata_i (rate_wdata_q),
    .raddr_i (iss_q[RATE_AW-1:0]),
    .rdata_o (rate_rd)
  );

  assign row_used   = (tbl_q == TBL_BLOCK) ? blk_rd.used : rate_rd.used;
  assign row_key    = (tbl_q == TBL_BLOCK) ? blk_rd.key : rate_rd.key;
  assign scan_lim   = (tbl_q == TBL_BLOCK) ? SCAN_W'(blk_hwm_q) : SCAN_W'(rate_hwm_q);
  assign tbl_depth  = (tbl_q == TBL_BLOCK) ? SCAN_W'(BLK_DEPTH) : SCAN_W'(RATE_DEPTH);
  assign scan_done  = hit_q || ((iss_q == scan_lim) && !chk_vld_q);
  assign place_idx  = hit_q ? ent_idx_q : (free_vld_q ? free_idx_q : scan_lim);
  assign place_grow = !hit_q && !free_vld_q;
  assign place_ok   = !place_grow || (scan_lim != tbl_depth);
  assign elapsed    = cur_q.now - rate_ent_q.start;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign q_pop_o     = (state_q == ST_IDLE) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      wlen_q      <= WINDOW_LEN_RST;
      limit_q     <= BYTE_LIMIT_RST;
      stat_q      <= '{default: '0};
      blk_hwm_q   <= '0;
      rate_hwm_q  <= '0;
      blk_we_q    <= 1'b0;
      rate_we_q   <= 1'b0;
      chk_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_vld_q  <= 1'b0;
    end else begin
      blk_we_q  <= 1'b0;
      rate_we_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_WINDOW_LEN: wlen_q <= cfg_wdata_i;
          CFG_BYTE_LIMIT: limit_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            cur_q      <= q_item_i;
            res_q      <= '0;
            iss_q      <= '0;
            chk_vld_q  <= 1'b0;
            hit_q      <= 1'b0;
            free_vld_q <= 1'b0;
            case (q_item_i.cmd)
              CMD_PACKET, CMD_WR_BLOCK, CMD_DEL_BLOCK: begin
                tbl_q   <= TBL_BLOCK;
                state_q <= ST_SCAN;
              end
              CMD_ADD_RATE, CMD_DEL_RATE, CMD_RD_TOTAL: begin
                tbl_q   <= TBL_RATE;
                state_q <= ST_SCAN;
              end
              CMD_RD_STAT: begin
                res_q.read_data <= stat_q[q_item_i.sidx];
                state_q         <= ST_FINISH;
              end
              default: state_q <= ST_FINISH;
            endcase
          end
        end

        ST_SCAN: begin
          if (!scan_done) begin
            if (iss_q != scan_lim) begin
              iss_q <= iss_q + SCAN_W'(1);
            end
            chk_vld_q <= (iss_q != scan_lim);
            chk_idx_q <= iss_q;
            if (chk_vld_q) begin
              if (row_used && (row_key == cur_q.key)) begin
                hit_q      <= 1'b1;
                ent_idx_q  <= chk_idx_q;
                blk_ent_q  <= blk_rd;
                rate_ent_q <= rate_rd;
              end else if (!row_used && !free_vld_q) begin
                free_vld_q <= 1'b1;
                free_idx_q <= chk_idx_q;
              end
            end
          end else begin
            state_q <= ST_FINISH;
            case (cur_q.cmd)
              CMD_PACKET: begin
                if (tbl_q == TBL_BLOCK) begin
                  if (hit_q && (blk_ent_q.val == BLOCK_QUARANTINE)) begin
                    res_q.drop <= 1'b1;
                    if (cur_q.iph) begin
                      res_q.event_valid    <= 1'b1;
                      res_q.event_reason   <= REASON_QUARANTINE;
                      res_q.event_flow_key <= cur_q.key;
                      res_q.event_address  <= cur_q.addr;
                      res_q.event_port     <= cur_q.evport;
                      res_q.event_protocol <= cur_q.proto;
                      res_q.event_length   <= cur_q.len;
                      res_q.event_time     <= cur_q.now;
                    end
                    stat_q[STAT_PKT_DROP]  <= stat_q[STAT_PKT_DROP] + 64'd1;
                    stat_q[STAT_BYTE_DROP] <= stat_q[STAT_BYTE_DROP] + 64'(cur_q.len);
                  end else begin
                    tbl_q      <= TBL_RATE;
                    iss_q      <= '0;
                    chk_vld_q  <= 1'b0;
                    hit_q      <= 1'b0;
                    free_vld_q <= 1'b0;
                    state_q    <= ST_SCAN;
                  end
                end else begin
                  state_q <= hit_q ? ST_CALC : ST_APPLY;
                end
              end
              CMD_WR_BLOCK: begin
                if (place_ok) begin
                  blk_we_q    <= 1'b1;
                  blk_waddr_q <= place_idx[BLK_AW-1:0];
                  blk_wdata_q <= '{used: 1'b1, key: cur_q.key, val: cur_q.bval};
                  if (place_grow) begin
                    blk_hwm_q <= blk_hwm_q + BLK_CW'(1);
                  end
                end else begin
                  res_q.status <= STS_FULL;
                end
              end
              CMD_DEL_BLOCK: begin
                if (hit_q) begin
                  blk_we_q    <= 1'b1;
                  blk_waddr_q <= ent_idx_q[BLK_AW-1:0];
                  blk_wdata_q <= '0;
                end else begin
                  res_q.status <= STS_NOT_FOUND;
                end
              end
              CMD_ADD_RATE: begin
                if (place_ok) begin
                  rate_we_q    <= 1'b1;
                  rate_waddr_q <= place_idx[RATE_AW-1:0];
                  rate_wdata_q <= '{used: 1'b1, key: cur_q.key, start: cur_q.now,
                                    wbytes: 64'd0, total: 64'd0};
                  if (place_grow) begin
                    rate_hwm_q <= rate_hwm_q + RATE_CW'(1);
                  end
                end else begin
                  res_q.status <= STS_FULL;
                end
              end
              CMD_DEL_RATE: begin
                if (hit_q) begin
                  rate_we_q    <= 1'b1;
                  rate_waddr_q <= ent_idx_q[RATE_AW-1:0];
                  rate_wdata_q <= '0;
                end else begin
                  res_q.status <= STS_NOT_FOUND;
                end
              end
              CMD_RD_TOTAL: begin
                if (hit_q) begin
                  res_q.read_data <= rate_ent_q.total;
                end else begin
                  res_q.status <= STS_NOT_FOUND;
                end
              end
              default: ;
            endcase
          end
        end

        ST_CALC: begin
          win_restart_q <= (elapsed >= 64'(wlen_q));
          win_sum_q     <= rate_ent_q.wbytes + 64'(cur_q.len);
          tot_sum_q     <= rate_ent_q.total + 64'(cur_q.len);
          state_q       <= ST_RATE;
        end

        ST_RATE: begin
          rate_we_q    <= 1'b1;
          rate_waddr_q <= ent_idx_q[RATE_AW-1:0];
          if (win_restart_q) begin
            rate_wdata_q <= '{used: 1'b1, key: cur_q.key, start: cur_q.now,
                              wbytes: 64'(cur_q.len), total: tot_sum_q};
            state_q      <= ST_APPLY;
          end else if (win_sum_q > 64'(limit_q)) begin
            rate_wdata_q <= '{used: 1'b1, key: cur_q.key, start: rate_ent_q.start,
                              wbytes: win_sum_q, total: rate_ent_q.total};
            res_q.drop             <= 1'b1;
            stat_q[STAT_PKT_DROP]  <= stat_q[STAT_PKT_DROP] + 64'd1;
            stat_q[STAT_BYTE_DROP] <= stat_q[STAT_BYTE_DROP] + 64'(cur_q.len);
            state_q                <= ST_FINISH;
          end else begin
            rate_wdata_q <= '{used: 1'b1, key: cur_q.key, start: rate_ent_q.start,
                              wbytes: win_sum_q, total: tot_sum_q};
            state_q      <= ST_APPLY;
          end
        end

        ST_APPLY: begin
          if (cur_q.alert) begin
            res_q.event_valid    <= 1'b1;
            res_q.event_reason   <= REASON_ALERT;
            res_q.event_flow_key <= cur_q.key;
            res_q.event_address  <= cur_q.addr;
            res_q.event_port     <= cur_q.evport;
            res_q.event_protocol <= PROTO_TCP;
            res_q.event_length   <= cur_q.len;
            res_q.event_time     <= cur_q.now;
          end
          stat_q[STAT_PKT_PASS]  <= stat_q[STAT_PKT_PASS] + 64'd1;
          stat_q[STAT_BYTE_PASS] <= stat_q[STAT_BYTE_PASS] + 64'(cur_q.len);
          state_q                <= ST_FINISH;
        end

        ST_FINISH: begin
          if (out_free) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_blk_hwm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_hwm_q <= BLK_CW'(BLK_DEPTH)) else $error("block fill count beyond depth");

  a_rate_hwm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rate_hwm_q <= RATE_CW'(RATE_DEPTH)) else $error("rate fill count beyond depth");

  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && hit_q) |-> (ent_idx_q < scan_lim))
    else $error("scan hit outside the filled region");

  a_drop_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.drop && out_q.event_valid) |->
      (out_q.event_reason == REASON_QUARANTINE))
    else $error("dropped item carries an alert event");

endmodule

// ===== hdl/egress_flow_filter_rate_limiter_core.sv =====
// Top level of the egress flow filter with a fixed-window rate limiter.
//
//   Channel  Handshake                     Payload
//   in       in_valid_i / in_stall_o       command_i .. dest_port_i
//   out      out_valid_o / out_stall_i     status_o .. read_data_o
//   cfg      cfg_we_i                      cfg_addr_i, cfg_wdata_i
//
// A read stat or unused command skips the table scan and goes straight to its result.
// Table commands scan the filled part of their table, one entry per cycle
// through the RAM read port; a packet can scan both tables, first the block
// table and then, unless it is quarantined, the rate table.
// After reset the tables are empty and no clearing pass is needed.
// A two-item queue lets input items be taken while the output is stalled.
module egress_flow_filter_rate_limiter_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [eff_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [eff_pkg::CFG_DW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 command_i,
  input  logic [63:0]                flow_key_i,
  input  logic [7:0]                 block_value_i,
  input  logic [1:0]                 stat_index_i,
  input  logic [15:0]                packet_length_i,
  input  logic [63:0]                time_now_ns_i,
  input  logic                       ip_header_present_i,
  input  logic                       l4_header_present_i,
  input  logic [7:0]                 ip_protocol_i,
  input  logic [31:0]                dest_address_i,
  input  logic [15:0]                dest_port_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic                       drop_o,
  output logic                       event_valid_o,
  output logic                       event_reason_o,
  output logic [63:0]                event_flow_key_o,
  output logic [31:0]                event_address_o,
  output logic [15:0]                event_port_o,
  output logic [7:0]                 event_protocol_o,
  output logic [15:0]                event_length_o,
  output logic [63:0]                event_time_o,
  output logic [63:0]                read_data_o
);
  import eff_pkg::*;

  item_t push_item;
  item_t head_item;
  logic  push;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  res_t  res;

  eff_front u_front (
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .command_i           (command_i),
    .flow_key_i          (flow_key_i),
    .block_value_i       (block_value_i),
    .stat_index_i        (stat_index_i),
    .packet_length_i     (packet_length_i),
    .time_now_ns_i       (time_now_ns_i),
    .ip_header_present_i (ip_header_present_i),
    .l4_header_present_i (l4_header_present_i),
    .ip_protocol_i       (ip_protocol_i),
    .dest_address_i      (dest_address_i),
    .dest_port_i         (dest_port_i),
    .q_full_i            (q_full),
    .push_o              (push),
    .item_o              (push_item)
  );

  eff_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (head_item)
  );

  eff_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign status_o         = res.status;
  assign drop_o           = res.drop;
  assign event_valid_o    = res.event_valid;
  assign event_reason_o   = res.event_reason;
  assign event_flow_key_o = res.event_flow_key;
  assign event_address_o  = res.event_address;
  assign event_port_o     = res.event_port;
  assign event_protocol_o = res.event_protocol;
  assign event_length_o   = res.event_length;
  assign event_time_o     = res.event_time;
  assign read_data_o      = res.read_data;

endmodule
